// File: rtl/core/assert_macros.svh
// assertion macros for the checker, clocked on clk_i and quiet in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/fp4gsdp_pkg.sv
`default_nettype none
package fp4gsdp_pkg;

  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_INF  = 32'h7F80_0000;

  localparam logic [1:0] OP_MUL_AW = 2'd0;
  localparam logic [1:0] OP_MUL_S  = 2'd1;
  localparam logic [1:0] OP_ADD    = 2'd2;

  localparam logic [5:0] MUL_FRAC = 6'd46;
  localparam logic [5:0] ADD_FRAC = 6'd49;

  localparam logic [30:0] E2M1_MAG [8] = '{
    31'h0000_0000, 31'h3F00_0000, 31'h3F80_0000, 31'h3FC0_0000,
    31'h4000_0000, 31'h4040_0000, 31'h4080_0000, 31'h40C0_0000
  };

  typedef struct packed {
    logic              capture;
    logic [1:0]        op;
    logic              elem;
    logic              wr_tmp;
    logic              wr_sum;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic row_end;
  } status_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        spec_val;
    logic               sign;
    logic [63:0]        x;
    logic signed [12:0] e;
    logic [5:0]         f;
  } stage_t;

  function automatic logic [31:0] e2m1_to_fp32(input logic [3:0] nib);
    return {nib[3], E2M1_MAG[nib[2:0]]};
  endfunction

  function automatic stage_t fp_mul_front(input logic [31:0] a, input logic [31:0] b);
    stage_t r;
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    r = '0;
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    prod = ma * mb;
    r.sign = a[31] ^ b[31];
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      r.special  = 1'b1;
      r.spec_val = FP_QNAN;
    end else if (inf_a || inf_b) begin
      r.special  = 1'b1;
      r.spec_val = {r.sign, FP_INF[30:0]};
    end else if (zero_a || zero_b) begin
      r.special  = 1'b1;
      r.spec_val = {r.sign, 31'd0};
    end else begin
      r.x = {16'd0, prod};
      r.e = $signed({5'd0, ea}) + $signed({5'd0, eb}) - 13'sd127;
      r.f = MUL_FRAC;
    end
    return r;
  endfunction

  function automatic stage_t fp_add_front(input logic [31:0] a, input logic [31:0] b);
    stage_t r;
    logic [31:0] big, sml;
    logic [7:0] eg, es, dd;
    logic [5:0] sh;
    logic [49:0] aw, bw, bs;
    logic st;
    logic [50:0] s;
    r = '0;
    if (((a[30:23] == 8'hFF) && (a[22:0] != 23'd0)) ||
        ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) ||
        ((a[30:0] == FP_INF[30:0]) && (b[30:0] == FP_INF[30:0]) && (a[31] != b[31]))) begin
      r.special  = 1'b1;
      r.spec_val = FP_QNAN;
    end else if (a[30:0] == FP_INF[30:0]) begin
      r.special  = 1'b1;
      r.spec_val = a;
    end else if (b[30:0] == FP_INF[30:0]) begin
      r.special  = 1'b1;
      r.spec_val = b;
    end else begin
      if (b[30:0] > a[30:0]) begin
        big = b;
        sml = a;
      end else begin
        big = a;
        sml = b;
      end
      eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      dd = eg - es;
      sh = (dd > 8'd63) ? 6'd63 : dd[5:0];
      aw = {big[30:23] != 8'd0, big[22:0], 26'd0};
      bw = {sml[30:23] != 8'd0, sml[22:0], 26'd0};
      bs = bw >> sh;
      st = ((bs << sh) != bw);
      bs = bs | {49'd0, st};
      if (big[31] != sml[31]) s = {1'b0, aw} - {1'b0, bs};
      else s = {1'b0, aw} + {1'b0, bs};
      r.sign = big[31];
      if (s == 51'd0) begin
        r.special  = 1'b1;
        r.spec_val = {a[31] & b[31], 31'd0};
      end else begin
        r.x = {13'd0, s};
        r.e = $signed({5'd0, eg});
        r.f = ADD_FRAC;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_norm_round(input stage_t st);
    logic [5:0] lead;
    logic signed [13:0] er, sh, nsh;
    logic [6:0] shamt;
    logic [89:0] wide, shd;
    logic [23:0] m;
    logic g, stk;
    logic [25:0] mr;
    logic [13:0] expo;
    logic [31:0] w;
    lead = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (st.x[i]) lead = 6'(i);
    end
    er = $signed({st.e[12], st.e}) + $signed({8'd0, lead}) - $signed({8'd0, st.f});
    sh = $signed({8'd0, lead}) - 14'sd23;
    if (er < 14'sd1) begin
      sh = sh + 14'sd1 - er;
      er = 14'sd1;
    end
    if (sh < 14'sd0) begin
      nsh = -sh;
      m = st.x[23:0] << nsh[4:0];
      g = 1'b0;
      stk = 1'b0;
    end else begin
      shamt = (sh > 14'sd74) ? 7'd74 : sh[6:0];
      wide = {st.x, 26'd0};
      shd = wide >> shamt;
      m = shd[49:26];
      g = shd[25];
      stk = (|shd[24:0]) | ((shd << shamt) != wide);
    end
    mr = {2'd0, m} + {25'd0, g & (stk | m[0])};
    expo = er - 14'sd1;
    if (expo > 14'd254) return {st.sign, FP_INF[30:0]};
    w = {1'b0, expo[7:0], 23'd0} + {6'd0, mr};
    if (w[31] || (w[30:0] >= FP_INF[30:0])) return {st.sign, FP_INF[30:0]};
    return {st.sign, w[30:0]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/fp4_group_scaled_dot_product.sv
`default_nettype none
// channel  | valid       | stall        | payload
// ---------+-------------+--------------+--------------------------------------------
// in       | in_valid_i  | in_stall_o   | weight_pair_i act_even_i act_odd_i
//          |             |              | group_scale_i row_end_i
// out      | out_valid_o | out_stall_i  | row_sum_o
//
// one item is two elements, each a multiply, a multiply by the group scale
// and an accumulate add, each fp op a front and a round step in the shared fp unit
// a row end adds an emit state to write the output register; it waits while stalled
// reset clears the running sum to +0 and empties the output register
// a waiting result blocks the input only when the next row end finds it still unread
module fp4_group_scaled_dot_product
  import fp4gsdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  weight_pair_i,
  input  wire logic [15:0] act_even_i,
  input  wire logic [15:0] act_odd_i,
  input  wire logic [31:0] group_scale_i,
  input  wire logic        row_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      row_sum_o
);

  cmd_t    cmd;
  status_t status;

  fp4gsdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fp4gsdp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .weight_pair_i (weight_pair_i),
    .act_even_i    (act_even_i),
    .act_odd_i     (act_odd_i),
    .group_scale_i (group_scale_i),
    .row_end_i     (row_end_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .row_sum_o     (row_sum_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/fp4gsdp_ctrl.sv
`default_nettype none
module fp4gsdp_ctrl
  import fp4gsdp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_RND1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_RND2 = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_RND3 = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state_q, state_d;
  logic       elem_q, elem_d;
  logic       oval_q, oval_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    elem_d  = elem_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o   = '0;
    cmd_o.elem = elem_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          elem_d  = 1'b0;
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL_AW;
        state_d  = S_RND1;
      end
      S_RND1: begin
        cmd_o.wr_tmp = 1'b1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = OP_MUL_S;
        state_d  = S_RND2;
      end
      S_RND2: begin
        cmd_o.wr_tmp = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        state_d  = S_RND3;
      end
      S_RND3: begin
        cmd_o.wr_sum = 1'b1;
        if (!elem_q) begin
          elem_d  = 1'b1;
          state_d = S_MUL1;
        end else if (status_i.row_end) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!oval_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          oval_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      elem_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      elem_q  <= elem_d;
      oval_q  <= oval_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fp4gsdp_dp.sv
`default_nettype none
module fp4gsdp_dp
  import fp4gsdp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  weight_pair_i,
  input  wire logic [15:0] act_even_i,
  input  wire logic [15:0] act_odd_i,
  input  wire logic [31:0] group_scale_i,
  input  wire logic        row_end_i,
  input  wire cmd_t        cmd_i,
  output status_t          status_o,
  output logic [31:0]      row_sum_o
);

  logic [7:0]  wpair_q;
  logic [15:0] act_e_q, act_o_q;
  logic [31:0] scale_q;
  logic        end_q;
  logic [31:0] tmp_q, sum_q, rsum_q;
  stage_t      stage_q, stage_d;
  logic [31:0] rnd;
  logic [31:0] act_fp, w_fp;

  assign act_fp = {cmd_i.elem ? act_o_q : act_e_q, 16'd0};
  assign w_fp   = e2m1_to_fp32(cmd_i.elem ? wpair_q[7:4] : wpair_q[3:0]);

  always_comb begin
    unique case (cmd_i.op)
      OP_MUL_AW: stage_d = fp_mul_front(act_fp, w_fp);
      OP_MUL_S:  stage_d = fp_mul_front(tmp_q, scale_q);
      OP_ADD:    stage_d = fp_add_front(sum_q, tmp_q);
      default:   stage_d = fp_add_front(sum_q, tmp_q);
    endcase
  end

  assign rnd = stage_q.special ? stage_q.spec_val : fp_norm_round(stage_q);

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    if (cmd_i.capture) begin
      wpair_q <= weight_pair_i;
      act_e_q <= act_even_i;
      act_o_q <= act_odd_i;
      scale_q <= group_scale_i;
      end_q   <= row_end_i;
    end
    if (cmd_i.wr_tmp) tmp_q <= rnd;
    if (cmd_i.emit) begin
      rsum_q <= ((sum_q[30:23] == 8'hFF) && (sum_q[22:0] != 23'd0)) ? FP_QNAN : sum_q;
    end
  end

  // the running sum carries over between items, so it gets a reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0;
    end else if (cmd_i.emit) begin
      sum_q <= 32'd0;
    end else if (cmd_i.wr_sum) begin
      sum_q <= rnd;
    end
  end

  assign status_o.row_end = end_q;
  assign row_sum_o = rsum_q;

endmodule
`default_nettype wire

// File: rtl/core/fp4gsdp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module fp4gsdp_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] row_sum_o
);

  // the block is busy right after taking a transaction
  `AST_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // a result cannot appear in the cycle after a transaction is taken
  `AST_NEXT(a_no_early_result, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o)
  // nan results come out canonical
  `AST_IMPL(a_canon_nan, out_valid_o && (row_sum_o[30:23] == 8'hFF) && (row_sum_o[22:0] != 23'd0),
            row_sum_o == 32'h7FC0_0000)
  `AST_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(row_sum_o))

endmodule

bind fp4_group_scaled_dot_product fp4gsdp_sva u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .row_sum_o   (row_sum_o)
);
`default_nettype wire
